// ===== sv/prqs_pkg.sv =====
// Package for the priority ready-queue scheduler: item types, operation codes
// and the command and status groups between controller and datapath.
// No dependencies.
package prqs_pkg;

    localparam int OP_W      = 2;
    localparam int TASK_ID_W = 5;
    localparam int PRIO_W    = 6;

    typedef enum logic [OP_W-1:0] {
        OP_MAKE_READY = 2'd0,
        OP_WAKEUP     = 2'd1,
        OP_YIELD      = 2'd2,
        OP_SLEEP      = 2'd3
    } op_t;

    typedef struct packed {
        op_t                  operation;
        logic [TASK_ID_W-1:0] task_id;
        logic [PRIO_W-1:0]    priority_req;
    } in_item_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] running_task;
        logic                 running_valid;
        logic                 switched;
        logic                 status;
    } out_item_t;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic load;
        logic enq_sel_cur;
        logic enq_rd;
        logic enq_wr;
        logic find_grp;
        logic find_pick;
        logic deq_rd;
        logic deq_cmp;
        logic deq_wr;
        logic commit_switch;
        logic commit_fail;
        logic fail_clear;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic found;
        logic pop_last;
        logic cur_valid;
    } sts_t;

endpackage

// ===== sv/prqs_datapath.sv =====
// Datapath of the priority ready-queue scheduler: head, tail and link stores,
// ready bitmap, two-stage level search, running task and result register.
// Depends on prqs_pkg.
module prqs_datapath #(
    parameter int PRIORITY_LEVELS = 64,
    parameter int MAX_TASKS       = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  prqs_pkg::in_item_t  s_item,
    input  prqs_pkg::cmd_t      cmd,
    output prqs_pkg::sts_t      sts,
    output prqs_pkg::out_item_t m_item
);
    localparam int LW  = $clog2(PRIORITY_LEVELS);
    localparam int TW  = $clog2(MAX_TASKS);
    localparam int GRP = 8;
    localparam int GIW = 3;
    localparam int NG  = (PRIORITY_LEVELS + GRP - 1) / GRP;

    logic [TW-1:0] head_mem [PRIORITY_LEVELS];
    logic [TW-1:0] tail_mem [PRIORITY_LEVELS];
    logic [TW-1:0] link_mem [MAX_TASKS];

    logic [PRIORITY_LEVELS-1:0] bitmap_reg, bitmap_next;
    logic [TW-1:0]              tid_reg;
    logic [LW-1:0]              lvl_reg;
    logic [TW-1:0]              tid_next;
    logic [LW-1:0]              lvl_next;
    logic [TW-1:0]              head_rd_reg, tail_rd_reg, link_rd_reg;
    logic [NG-1:0]              grp_any_reg, grp_any_next;
    logic [NG-1:0][GIW-1:0]     grp_idx_reg, grp_idx_next;
    logic                       found_reg, found_next;
    logic [LW-1:0]              best_reg, best_next;
    logic [TW-1:0]              cur_task_reg;
    logic [LW-1:0]              cur_pri_reg;
    logic                       cur_valid_reg;
    logic                       switched_reg, status_reg;
    logic [TW-1:0]              enq_task;
    logic [LW-1:0]              enq_lvl;
    logic [LW-1:0]              tail_addr;
    logic                       pop_last;
    logic [NG*GRP-1:0]          bm_pad;

    // Wrap the task id and saturate the level
    always_comb begin
        logic [TW:0] r;
        r = '0;
        for (int i = prqs_pkg::TASK_ID_W - 1; i >= 0; i--) begin
            r = {r[TW-1:0], s_item.task_id[i]};
            if (r >= (TW+1)'(MAX_TASKS)) begin
                r = r - (TW+1)'(MAX_TASKS);
            end
        end
        tid_next = r[TW-1:0];
        if (int'(s_item.priority_req) >= PRIORITY_LEVELS) begin
            lvl_next = LW'(PRIORITY_LEVELS - 1);
        end else begin
            lvl_next = LW'(s_item.priority_req);
        end
    end

    assign enq_task  = cmd.enq_sel_cur ? cur_task_reg : tid_reg;
    assign enq_lvl   = cmd.enq_sel_cur ? cur_pri_reg : lvl_reg;
    assign tail_addr = cmd.deq_rd ? best_reg : enq_lvl;
    assign pop_last  = (head_rd_reg == tail_rd_reg);

    always_comb begin
        bitmap_next = bitmap_reg;
        if (cmd.enq_wr && !bitmap_reg[enq_lvl]) begin
            bitmap_next[enq_lvl] = 1'b1;
        end
        if (cmd.deq_cmp && pop_last) begin
            bitmap_next[best_reg] = 1'b0;
        end
    end

    // First search stage: lowest set bit within each group of eight levels
    always_comb begin
        bm_pad = '0;
        bm_pad[PRIORITY_LEVELS-1:0] = bitmap_reg;
        for (int g = 0; g < NG; g++) begin
            grp_any_next[g] = |bm_pad[g*GRP +: GRP];
            grp_idx_next[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (bm_pad[g*GRP + j]) begin
                    grp_idx_next[g] = GIW'(j);
                end
            end
        end
    end

    // Second stage: first non-empty group
    always_comb begin
        found_next = 1'b0;
        best_next  = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any_reg[g]) begin
                found_next = 1'b1;
                best_next  = LW'(g * GRP + int'(grp_idx_reg[g]));
            end
        end
    end

    // Stores
    always_ff @(posedge aclk) begin
        if (cmd.enq_wr && !bitmap_reg[enq_lvl]) begin
            head_mem[enq_lvl] <= enq_task;
        end else if (cmd.deq_wr) begin
            head_mem[best_reg] <= link_rd_reg;
        end
        if (cmd.deq_rd) begin
            head_rd_reg <= head_mem[best_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enq_wr) begin
            tail_mem[enq_lvl] <= enq_task;
        end
        if (cmd.enq_rd || cmd.deq_rd) begin
            tail_rd_reg <= tail_mem[tail_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enq_wr && bitmap_reg[enq_lvl]) begin
            link_mem[tail_rd_reg] <= enq_task;
        end
        if (cmd.deq_cmp) begin
            link_rd_reg <= link_mem[head_rd_reg];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bitmap_reg    <= '0;
            cur_task_reg  <= '0;
            cur_pri_reg   <= '0;
            cur_valid_reg <= 1'b0;
        end else begin
            bitmap_reg <= bitmap_next;
            if (cmd.commit_switch) begin
                cur_task_reg  <= head_rd_reg;
                cur_pri_reg   <= best_reg;
                cur_valid_reg <= 1'b1;
            end else if (cmd.commit_fail && cmd.fail_clear) begin
                cur_task_reg  <= '0;
                cur_pri_reg   <= '0;
                cur_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            tid_reg      <= tid_next;
            lvl_reg      <= lvl_next;
            switched_reg <= 1'b0;
            status_reg   <= 1'b0;
        end else begin
            if (cmd.commit_switch) begin
                switched_reg <= 1'b1;
            end
            if (cmd.commit_fail) begin
                status_reg <= 1'b1;
            end
        end
        if (cmd.find_grp) begin
            grp_any_reg <= grp_any_next;
            grp_idx_reg <= grp_idx_next;
        end
        if (cmd.find_pick) begin
            found_reg <= found_next;
            best_reg  <= best_next;
        end
        if (cmd.out_load) begin
            m_item.running_task  <= cur_valid_reg ?
                prqs_pkg::TASK_ID_W'(cur_task_reg) : '0;
            m_item.running_valid <= cur_valid_reg;
            m_item.switched      <= switched_reg;
            m_item.status        <= status_reg;
        end
    end

    assign sts.found     = found_reg;
    assign sts.pop_last  = pop_last;
    assign sts.cur_valid = cur_valid_reg;

endmodule

// ===== sv/prqs_ctrl.sv =====
// Controller of the priority ready-queue scheduler: sequences enqueue, search,
// pop, requeue and result hand-off. Depends on prqs_pkg.
module prqs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  prqs_pkg::op_t       op,
    output logic                m_valid,
    input  logic                m_ready,
    output prqs_pkg::cmd_t      cmd,
    input  prqs_pkg::sts_t      sts
);
    typedef enum logic [3:0] {
        IDLE, ENQ_RD, ENQ_WR, FIND1, FIND2, CHECK,
        DEQ_CMP, DEQ_WR, SWITCH, COMMIT, DONE
    } state_t;

    state_t        state_reg, state_next;
    prqs_pkg::op_t op_reg, op_next;
    logic          req_reg, req_next;
    logic          m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        req_next     = req_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.enq_sel_cur = req_reg;
        cmd.fail_clear  = (op_reg == prqs_pkg::OP_SLEEP);
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    op_next  = op;
                    req_next = 1'b0;
                    case (op)
                        prqs_pkg::OP_MAKE_READY, prqs_pkg::OP_WAKEUP: state_next = ENQ_RD;
                        default: state_next = FIND1;
                    endcase
                end
            end
            ENQ_RD: begin
                cmd.enq_rd = 1'b1;
                state_next = ENQ_WR;
            end
            ENQ_WR: begin
                cmd.enq_wr = 1'b1;
                if (req_reg) begin
                    state_next = COMMIT;
                end else if (op_reg == prqs_pkg::OP_MAKE_READY) begin
                    state_next = DONE;
                end else begin
                    state_next = FIND1;
                end
            end
            FIND1: begin
                cmd.find_grp = 1'b1;
                state_next   = FIND2;
            end
            FIND2: begin
                cmd.find_pick = 1'b1;
                state_next    = CHECK;
            end
            CHECK: begin
                if (sts.found) begin
                    cmd.deq_rd = 1'b1;
                    state_next = DEQ_CMP;
                end else begin
                    cmd.commit_fail = 1'b1;
                    state_next      = DONE;
                end
            end
            DEQ_CMP: begin
                cmd.deq_cmp = 1'b1;
                state_next  = sts.pop_last ? SWITCH : DEQ_WR;
            end
            DEQ_WR: begin
                cmd.deq_wr = 1'b1;
                state_next = SWITCH;
            end
            SWITCH: begin
                // put the running task back before handing over, except on sleep
                if (sts.cur_valid && op_reg != prqs_pkg::OP_SLEEP) begin
                    req_next   = 1'b1;
                    state_next = ENQ_RD;
                end else begin
                    state_next = COMMIT;
                end
            end
            COMMIT: begin
                cmd.commit_switch = 1'b1;
                state_next        = DONE;
            end
            DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            op_reg      <= prqs_pkg::OP_MAKE_READY;
            req_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            req_reg     <= req_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== sv/priority_ready_queue_scheduler.sv =====
// Multilevel priority ready-queue scheduler. One FIFO of task ids per level
// (level 0 highest) lives in head, tail and link stores with a ready bit per
// level. Each item is one operation and gives one result item. Items are
// handled one at a time: make_ready presents its result after the enqueue
// read and write, a reschedule later (a search that finds nothing is
// quickest, a wakeup that pops from a longer queue and requeues the running
// task slowest), and the next item is accepted once the controller is back
// in idle. The steps are the controller's single-port store accesses
// (one registered read or one write per store and cycle) and the two-stage
// search over the ready bits. A finished result waits in the output register
// while the next item is accepted; a second finished result holds the
// controller until the first is taken. Depends on prqs_pkg, prqs_ctrl and
// prqs_datapath.
module priority_ready_queue_scheduler #(
    parameter int PRIORITY_LEVELS = 64,
    parameter int MAX_TASKS       = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  prqs_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output prqs_pkg::out_item_t m_item
);
    prqs_pkg::cmd_t cmd;
    prqs_pkg::sts_t sts;

    prqs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .op      (s_item.operation),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    prqs_datapath #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .MAX_TASKS       (MAX_TASKS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .sts     (sts),
        .m_item  (m_item)
    );

endmodule
